// ===== rtl/nae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_pkg: shared types for the no-adjacent-equal rearranger
// Transfer payloads, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package nae_pkg;

   localparam int LETTER_W = 5;
   localparam int SYMBOL_W = 5;
   localparam int STATUS_W = 2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_PULL   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IMPOSSIBLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;

   typedef struct packed {
      logic                operation;
      logic [SYMBOL_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic append;
      logic scan_init;
      logic scan_step;
      logic write_a;
      logic write_b;
      logic write_single;
      logic set_failed;
      logic set_computed;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic computed;
      logic len_zero;
      logic idx_last;
      logic best_vld;
      logic sec_vld;
      logic best_gt1;
      logic rsp_free;
   } sts_type;

endpackage : nae_pkg
`default_nettype wire

// ===== rtl/nae_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath through the count
// scan, the result store writes and the result emission.
// ----------------------------------------------------------------------------
module nae_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_operation,
   output      logic             req_stall,
   output      nae_pkg::cmd_type cmd,
   input  wire nae_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_DECIDE = 7'b0000100,
      ST_WRA    = 7'b0001000,
      ST_WRB    = 7'b0010000,
      ST_FETCH  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == nae_pkg::OP_APPEND) begin
                  cmd.append = 1'b1;
               end else if (!sts.computed && !sts.len_zero) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.idx_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.best_vld) begin
               cmd.set_computed = 1'b1;
               state_in         = ST_FETCH;
            end else if (!sts.sec_vld) begin
               // one letter left: fits only if a single copy remains
               cmd.set_computed = 1'b1;
               cmd.set_failed   = sts.best_gt1;
               cmd.write_single = !sts.best_gt1;
               state_in         = ST_FETCH;
            end else begin
               state_in = ST_WRA;
            end
         end
         ST_WRA: begin
            cmd.write_a = 1'b1;
            state_in    = ST_WRB;
         end
         ST_WRB: begin
            cmd.write_b   = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : nae_ctrl
`default_nettype wire

// ===== rtl/nae_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_datapath: letter counts, top-two scan, result store, output register
// Counts sit in flops with one read port; the scan visits one count a cycle.
// ----------------------------------------------------------------------------
module nae_datapath #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire nae_pkg::cmd_type cmd,
   output      nae_pkg::sts_type sts,
   input  wire nae_pkg::req_type req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      nae_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int IW = $clog2(ALPHABET);
   localparam int LW = nae_pkg::LETTER_W;

   logic [CW-1:0] cnt_ff [ALPHABET];
   logic [IW-1:0] store [MAX_LEN];

   logic [CW-1:0] len_ff, rp_ff, pos_ff;
   logic          computed_ff, failed_ff;
   logic [IW-1:0] idx_ff, best_ff, sec_ff;
   logic [CW-1:0] best_cnt_ff, sec_cnt_ff;
   logic          best_vld_ff, sec_vld_ff;
   logic [IW-1:0] rd_data_ff;
   logic          rsp_valid_ff;
   nae_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] sym_idx, cnt_addr;
   logic [CW-1:0] cnt_rd;
   logic          sym_ok, app_ok, rsp_free, clear;
   logic [AW-1:0] wr_addr;
   logic [IW-1:0] wr_data;
   logic          wr_en;
   logic [CW:0]   rp_next;

   assign sym_idx  = IW'(req_payload.symbol);
   assign sym_ok   = (9'(req_payload.symbol) < 9'(ALPHABET));
   assign app_ok   = cmd.append && !computed_ff && sym_ok && (len_ff < CW'(MAX_LEN));

   always_comb begin
      if (cmd.scan_step)    cnt_addr = idx_ff;
      else if (cmd.write_a) cnt_addr = best_ff;
      else if (cmd.write_b) cnt_addr = sec_ff;
      else                  cnt_addr = sym_idx;
   end
   assign cnt_rd = cnt_ff[cnt_addr];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rp_next  = (CW+1)'(rp_ff) + (CW+1)'(1);

   always_comb begin
      rsp_in = '0;
      if (len_ff == '0) begin
         rsp_in.status = nae_pkg::STATUS_EMPTY;
         rsp_in.last   = 1'b1;
      end else if (failed_ff) begin
         rsp_in.status = nae_pkg::STATUS_IMPOSSIBLE;
         rsp_in.last   = 1'b1;
      end else begin
         rsp_in.status = nae_pkg::STATUS_OK;
         rsp_in.letter = LW'(rd_data_ff);
         rsp_in.last   = (rp_next >= (CW+1)'(len_ff));
      end
   end
   assign clear = cmd.emit && rsp_in.last;

   // counts and block state
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < ALPHABET; i++) cnt_ff[i] <= '0;
         len_ff      <= '0;
         rp_ff       <= '0;
         pos_ff      <= '0;
         computed_ff <= 1'b0;
         failed_ff   <= 1'b0;
      end else begin
         if (app_ok) begin
            cnt_ff[cnt_addr] <= cnt_rd + CW'(1);
            len_ff           <= len_ff + CW'(1);
         end
         if (cmd.write_a || cmd.write_b) cnt_ff[cnt_addr] <= cnt_rd - CW'(1);
         if (cmd.write_b)      pos_ff      <= pos_ff + CW'(2);
         if (cmd.set_computed) computed_ff <= 1'b1;
         if (cmd.set_failed)   failed_ff   <= 1'b1;
         if (cmd.emit)         rp_ff       <= CW'(rp_next);
      end
   end

   // top-two scan: ties go to the later (higher) index
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init) begin
         idx_ff      <= '0;
         best_vld_ff <= 1'b0;
         sec_vld_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IW'(1);
         if (cnt_rd != '0) begin
            if (!best_vld_ff || cnt_rd >= best_cnt_ff) begin
               sec_ff      <= best_ff;
               sec_cnt_ff  <= best_cnt_ff;
               sec_vld_ff  <= best_vld_ff;
               best_ff     <= idx_ff;
               best_cnt_ff <= cnt_rd;
               best_vld_ff <= 1'b1;
            end else if (!sec_vld_ff || cnt_rd >= sec_cnt_ff) begin
               sec_ff     <= idx_ff;
               sec_cnt_ff <= cnt_rd;
               sec_vld_ff <= 1'b1;
            end
         end
      end
   end

   // result store
   assign wr_en   = cmd.write_a || cmd.write_b || cmd.write_single;
   assign wr_addr = cmd.write_b ? AW'(pos_ff + CW'(1)) : AW'(pos_ff);
   assign wr_data = cmd.write_b ? sec_ff : best_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
      rd_data_ff <= store[rp_ff[AW-1:0]];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.computed = computed_ff;
   assign sts.len_zero = (len_ff == '0);
   assign sts.idx_last = (idx_ff == IW'(ALPHABET - 1));
   assign sts.best_vld = best_vld_ff;
   assign sts.sec_vld  = sec_vld_ff;
   assign sts.best_gt1 = (best_cnt_ff > CW'(1));
   assign sts.rsp_free = rsp_free;

endmodule : nae_datapath
`default_nettype wire

// ===== rtl/no_adjacent_equal_rearranger.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// no_adjacent_equal_rearranger: letter rearranger with no equal neighbors
// Request channel (req_*): operation append adds one letter, pull asks for
//   the next result. Requests are taken one at a time; req_stall is high
//   while a request is in progress.
// Result channel (rsp_*): one result per pull, none per append, held in an
//   output register so the next request can be taken while it waits.
// Append is taken in the idle state. A pull after the first passes
//   through a fetch state (store read) and an emit state. The first pull
//   runs P + 1 greedy steps, P the letter pairs placed (at most N/2 for
//   N letters); each scans the count file one letter per cycle, then
//   writes two letters through the single store write port.
// A result marked last (final letter, impossible or empty status) clears
//   counts, length and pointers. Letters past MAX_LEN or outside the
//   alphabet, and appends after the first pull, are dropped.
// Reset (synchronous) clears all control state; no clearing pass is needed.
// A stalled result holds in the output register; a pending pull waits for
//   it to drain before emitting.
// ----------------------------------------------------------------------------
module no_adjacent_equal_rearranger #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire nae_pkg::req_type req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      nae_pkg::rsp_type rsp_payload
);

   nae_pkg::cmd_type cmd;
   nae_pkg::sts_type sts;

   nae_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   nae_datapath #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != nae_pkg::STATUS_OK)
         |-> (rsp_payload.letter == '0 && rsp_payload.last))
      else $error("status result carries a letter or lacks last");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("result emitted over a pending transfer");

   a_pair_write: assert property (@(posedge clock) disable iff (reset)
      cmd.write_a |=> cmd.write_b)
      else $error("pair write not completed");

   a_single_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_single || cmd.set_failed) |-> cmd.set_computed)
      else $error("greedy ended without marking computed");

endmodule : no_adjacent_equal_rearranger
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for no_adjacent_equal_rearranger
// Strings of letters are appended and pulled back through the request
// channel. Every accepted request goes through a greedy-arrangement predictor,
// and each result transfer is checked field by field against the oldest
// prediction. Traffic runs in phases: full rate, sender gaps, receiver
// stalls, both, and one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_LEN   = 1024;
   localparam int ALPHABET  = 26;
   localparam int NO_LETTER = ALPHABET;
   localparam int PHASE_ITEMS = 160;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 64;
   // slowest legal quiet stretch: first pull of a full string,
   // about 513 greedy steps, each a full scan of the count file
   localparam int WATCHDOG_LIMIT = 80000;

   typedef enum {FULL_RATE, SENDER_GAPS, RECEIVER_GAPS, BOTH_GAPS, LONG_HOLD} traffic_mode_type;

   typedef struct {
      nae_pkg::req_type req;
      traffic_mode_type mode;
      bit               wait_drained;
   } stim_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   nae_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   nae_pkg::rsp_type rsp_payload;

   stim_entry_type   pending_requests[$];
   nae_pkg::rsp_type expected_results[$];
   traffic_mode_type traffic_mode = FULL_RATE;
   bit               stimulus_done = 1'b0;
   int               planned_items = 0;

   // predictor state
   int unsigned tally[ALPHABET];
   logic [4:0]  arranged[MAX_LEN];
   int unsigned loaded_len = 0;
   int unsigned read_ptr = 0;
   bit          arrangement_ready = 1'b0;
   bit          arrangement_failed = 1'b0;

   int mismatch_count = 0;
   int requests_taken = 0;
   int results_checked = 0;
   int strings_arranged = 0;
   int impossible_seen = 0;
   int empty_seen = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;

   no_adjacent_equal_rearranger #(
      .MAX_LEN (MAX_LEN),
      .ALPHABET(ALPHABET)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic clear_string();
      for (int i = 0; i < ALPHABET; i++) tally[i] = 0;
      loaded_len = 0;
      read_ptr = 0;
      arrangement_ready = 1'b0;
      arrangement_failed = 1'b0;
   endtask

   // highest nonzero count, ties to the higher letter, skipping one letter
   function automatic int busiest_letter(input int skip);
      int best;
      int unsigned best_count;
      best = NO_LETTER;
      best_count = 0;
      for (int i = 0; i < ALPHABET; i++) begin
         if (i != skip && tally[i] != 0 && tally[i] >= best_count) begin
            best = i;
            best_count = tally[i];
         end
      end
      return best;
   endfunction

   task automatic arrange_letters();
      int pos;
      int first;
      int second;
      pos = 0;
      strings_arranged++;
      while (1) begin
         first = busiest_letter(NO_LETTER);
         if (first == NO_LETTER) break;
         second = busiest_letter(first);
         if (second == NO_LETTER) begin
            if (tally[first] > 1) begin
               arrangement_failed = 1'b1;
            end else if (pos < MAX_LEN) begin
               arranged[pos] = first[4:0];
               pos++;
            end
            tally[first] = 0;
            break;
         end
         if (pos < MAX_LEN) arranged[pos] = first[4:0];
         if (pos + 1 < MAX_LEN) arranged[pos + 1] = second[4:0];
         pos += 2;
         tally[first]--;
         tally[second]--;
      end
      arrangement_ready = 1'b1;
   endtask

   task automatic model_request(input nae_pkg::req_type r);
      nae_pkg::rsp_type o;
      if (r.operation == nae_pkg::OP_APPEND) begin
         if (!arrangement_ready && r.symbol < ALPHABET && loaded_len < MAX_LEN) begin
            tally[r.symbol]++;
            loaded_len++;
         end
      end else begin
         if (!arrangement_ready && loaded_len != 0) arrange_letters();
         if (loaded_len == 0 || arrangement_failed) begin
            o.status = (loaded_len == 0) ? nae_pkg::STATUS_EMPTY
                                         : nae_pkg::STATUS_IMPOSSIBLE;
            o.letter = '0;
            o.last   = 1'b1;
            if (loaded_len == 0) empty_seen++;
            else impossible_seen++;
            clear_string();
         end else begin
            o.status = nae_pkg::STATUS_OK;
            o.letter = arranged[read_ptr];
            read_ptr++;
            o.last = (read_ptr >= loaded_len);
            if (o.last) clear_string();
         end
         expected_results.push_back(o);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int sender_gap_pct(input traffic_mode_type m);
      case (m)
         SENDER_GAPS: return 52;
         BOTH_GAPS:   return 13;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_gap_pct(input traffic_mode_type m);
      case (m)
         RECEIVER_GAPS: return 52;
         BOTH_GAPS:     return 13;
         default:       return 0;
      endcase
   endfunction

   task automatic queue_request(input logic op, input int sym, input traffic_mode_type mode,
                                input bit drained);
      stim_entry_type e;
      e.req.operation = op;
      e.req.symbol    = sym[4:0];
      e.mode          = mode;
      e.wait_drained  = drained;
      pending_requests.push_back(e);
      planned_items++;
   endtask

   // one string with random content, mostly well formed: n appends, then
   // pulls; sometimes over- or under-pulled, with ignored appends mixed in
   task automatic queue_string(input traffic_mode_type mode, input bit drained);
      int n;
      int span;
      int base;
      int lead;
      int pulls;
      int choice;
      bit lopsided;
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      span = $urandom_range(1, ALPHABET);
      base = $urandom_range(0, ALPHABET - span);
      lead = base + $urandom_range(span - 1);
      lopsided = ($urandom_range(7) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            queue_request(nae_pkg::OP_APPEND, $urandom_range(ALPHABET, 31), mode,
                          drained && i == 0);
         if (lopsided && $urandom_range(1) == 1)
            queue_request(nae_pkg::OP_APPEND, lead, mode, drained && i == 0);
         else
            queue_request(nae_pkg::OP_APPEND, base + $urandom_range(span - 1), mode,
                          drained && i == 0);
      end
      choice = $urandom_range(9);
      if (choice == 0) pulls = n + 1 + $urandom_range(2);
      else if (choice == 1) pulls = $urandom_range(1, n);
      else pulls = n;
      for (int j = 0; j < pulls; j++) begin
         queue_request(nae_pkg::OP_PULL, $urandom_range(31), mode, 1'b0);
         if ($urandom_range(11) == 0)
            queue_request(nae_pkg::OP_APPEND, $urandom_range(31), mode, 1'b0);
      end
   endtask

   task automatic queue_phase(input traffic_mode_type mode);
      int start;
      start = planned_items;
      queue_string(mode, 1'b1);
      while (planned_items - start < PHASE_ITEMS) queue_string(mode, 1'b0);
   endtask

   // full-length string with one letter one over half: impossible, unless
   // the appends past the length limit were wrongly counted
   task automatic queue_overflow_string();
      logic [4:0] pool[MAX_LEN];
      int dominant;
      int other;
      int j;
      logic [4:0] swap;
      dominant = $urandom_range(ALPHABET - 1);
      for (int i = 0; i < MAX_LEN; i++) begin
         other = $urandom_range(ALPHABET - 2);
         if (other >= dominant) other++;
         pool[i] = (i <= MAX_LEN / 2) ? dominant[4:0] : other[4:0];
      end
      for (int i = MAX_LEN - 1; i > 0; i--) begin
         j = $urandom_range(i);
         swap = pool[i];
         pool[i] = pool[j];
         pool[j] = swap;
      end
      for (int i = 0; i < MAX_LEN; i++)
         queue_request(nae_pkg::OP_APPEND, pool[i], FULL_RATE, i == 0);
      for (int i = 0; i < 3; i++)
         queue_request(nae_pkg::OP_APPEND, (dominant + 1) % ALPHABET, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
   endtask

   task automatic queue_directed();
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);        // empty input
      queue_request(nae_pkg::OP_APPEND, 0, FULL_RATE, 1'b0);      // single letter
      queue_request(nae_pkg::OP_PULL, 31, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 25, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 26, FULL_RATE, 1'b0);     // outside the alphabet
      queue_request(nae_pkg::OP_APPEND, 31, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 0, FULL_RATE, 1'b0);      // impossible, then empty
      queue_request(nae_pkg::OP_APPEND, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 25, FULL_RATE, 1'b0);     // z a z
      queue_request(nae_pkg::OP_APPEND, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 25, FULL_RATE, 1'b0);
      for (int i = 0; i < 3; i++) queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 1, FULL_RATE, 1'b0);      // equal counts: d c b
      queue_request(nae_pkg::OP_APPEND, 2, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 3, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_APPEND, 7, FULL_RATE, 1'b0);      // dropped after first pull
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
      queue_request(nae_pkg::OP_PULL, 0, FULL_RATE, 1'b0);
   endtask

   task automatic queue_hold_phase();
      for (int i = 0; i < 10; i++)
         queue_request(nae_pkg::OP_APPEND, (i % 5) * 5 + $urandom_range(4), LONG_HOLD,
                       i == 0);
      for (int i = 0; i < 10; i++) queue_request(nae_pkg::OP_PULL, 0, LONG_HOLD, 1'b0);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      stim_entry_type upcoming;
      bit hold_back;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            model_request(req_payload);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
               stimulus_done = 1'b1;
            end else begin
               upcoming = pending_requests[0];
               traffic_mode = upcoming.mode;
               hold_back = (upcoming.wait_drained && expected_results.size() != 0) ||
                           ($urandom_range(99) < sender_gap_pct(upcoming.mode));
               if (hold_back) begin
                  req_valid <= 1'b0;
               end else begin
                  req_valid   <= 1'b1;
                  req_payload <= upcoming.req;
                  void'(pending_requests.pop_front());
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      nae_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d letter %0d last %0d",
                                         rsp_payload.status, rsp_payload.letter,
                                         rsp_payload.last));
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_payload.status, want.status));
               if (rsp_payload.letter !== want.letter)
                  report_mismatch($sformatf("letter %0d, want %0d",
                                            rsp_payload.letter, want.letter));
               if (rsp_payload.last !== want.last)
                  report_mismatch($sformatf("last %0d, want %0d", rsp_payload.last, want.last));
            end
         end
         // long hold-off once, while the sender keeps offering pulls
         if (traffic_mode == LONG_HOLD && !hold_armed) begin
            hold_armed = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_gap_pct(traffic_mode));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_string();
      queue_directed();
      queue_phase(FULL_RATE);
      queue_overflow_string();
      queue_phase(SENDER_GAPS);
      queue_phase(RECEIVER_GAPS);
      queue_phase(BOTH_GAPS);
      queue_hold_phase();
      queue_phase(FULL_RATE);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_results.size() == 0)) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d arranged strings",
               requests_taken, results_checked, strings_arranged);
      $display("  %0d impossible, %0d empty pulls, one string past the length limit",
               impossible_seen, empty_seen);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== no_adjacent_equal_rearranger.f =====
rtl/nae_pkg.sv
rtl/nae_ctrl.sv
rtl/nae_datapath.sv
rtl/no_adjacent_equal_rearranger.sv
dv/testbench.sv
